// ----- rtl/core/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared constants and types for the two-axis step pulse planner.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int POS_BITS_DEF    = 20;
   localparam int PERIOD_BITS_DEF = 32;
   localparam int BASE_BITS       = 16;
   localparam logic [BASE_BITS-1:0] BASE_RESET = 16'd125;
   localparam int PERIOD_OFFSET   = 3;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_MOVE = 1'b1;

   typedef struct packed {
      logic toggle_x;
      logic toggle_y;
      logic dir_x;
      logic dir_y;
      logic busy_res;
      logic rejected;
   } rsp_type;

endpackage

// ----- rtl/core/tsp_if.sv -----
// ----------------------------------------------------------------------------
// tsp_req_if / tsp_rsp_if / tsp_csr_if
// Valid/ready channels for requests, responses and the register write port.
// ----------------------------------------------------------------------------
interface tsp_req_if #(parameter int POS_BITS = tsp_pkg::POS_BITS_DEF);
   logic                valid;
   logic                ready;
   logic                req_type;
   logic [POS_BITS-1:0] target_x;
   logic [POS_BITS-1:0] target_y;
   modport source (output valid, req_type, target_x, target_y, input ready);
   modport sink   (input valid, req_type, target_x, target_y, output ready);
endinterface

interface tsp_rsp_if;
   logic valid;
   logic ready;
   logic toggle_x;
   logic toggle_y;
   logic dir_x;
   logic dir_y;
   logic busy_res;
   logic rejected;
   modport source (output valid, toggle_x, toggle_y, dir_x, dir_y, busy_res, rejected,
                   input ready);
   modport sink   (input valid, toggle_x, toggle_y, dir_x, dir_y, busy_res, rejected,
                   output ready);
endinterface

interface tsp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tsp_pkg::BASE_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/tsp_alu.sv -----
// ----------------------------------------------------------------------------
// tsp_alu
// Shared iterative unit: restoring square root or restoring division,
// one bit per cycle.
// ----------------------------------------------------------------------------
module tsp_alu #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         is_div,
   input  logic [W-1:0] opa,
   input  logic [W-1:0] opb,
   output logic         done,
   output logic [W-1:0] result
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          div_ff, div_in;
   logic          done_ff, done_in;

   logic [W+1:0] trial;
   logic [W+1:0] shifted;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      shifted = '0;
      trial   = '0;
      if (start) begin
         num_in = opa;
         den_in = opb;
         rem_in = '0;
         quo_in = '0;
         div_in = is_div;
         run_in = 1'b1;
         cnt_in = is_div ? CW'(W) : CW'(W / 2);
      end else if (run_ff) begin
         if (div_ff) begin
            shifted = {1'b0, rem_ff, num_ff[W-1]};
            trial   = shifted - {2'b00, den_ff};
            num_in  = {num_ff[W-2:0], 1'b0};
            if (!trial[W+1]) begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
         end else begin
            shifted = {rem_ff, num_ff[W-1:W-2]};
            trial   = shifted - {quo_ff, 2'b01};
            num_in  = {num_ff[W-3:0], 2'b00};
            if (!trial[W+1]) begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;
endmodule

// ----- rtl/core/two_axis_step_pulse_planner_unit.sv -----
// ----------------------------------------------------------------------------
// two_axis_step_pulse_planner_unit
// Two-axis stepper linear interpolation: move planning and tick stepping.
// ----------------------------------------------------------------------------
// A tick beat's response is valid the cycle after the beat is taken; the next
// beat is taken only after that response is accepted. A move beat runs
// one shared bit-serial unit of 2*POS_BITS+2 bits (wider at small POS_BITS,
// where the base-times-length product needs more): a square root
// and two divisions, one per axis, in that order. Input is not ready while a
// beat is in work or its response waits.
module two_axis_step_pulse_planner_unit #(
   parameter int POS_BITS    = tsp_pkg::POS_BITS_DEF,
   parameter int PERIOD_BITS = tsp_pkg::PERIOD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tsp_req_if.sink   req,
   tsp_rsp_if.source rsp,
   tsp_csr_if.sink   csr
);
   localparam int DB = POS_BITS + 1;
   localparam int SB = 2 * DB;
   localparam int LB = DB;
   localparam int QB = tsp_pkg::BASE_BITS + LB;
   localparam int AW = (SB > QB ? SB : QB) + (SB > QB ? SB : QB) % 2;
   localparam int TB = POS_BITS + 2;
   localparam logic [PERIOD_BITS-1:0] PMAX = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_SQRT, S_DIVX, S_DIVY, S_RESP
   } state_type;

   state_type             state_ff;
   logic [tsp_pkg::BASE_BITS-1:0] base_ff;
   logic [POS_BITS-1:0]   pos_x_ff, pos_y_ff, goal_x_ff, goal_y_ff;
   logic [TB-1:0]         left_x_ff, left_y_ff;
   logic [PERIOD_BITS-1:0] period_x_ff, period_y_ff, count_x_ff, count_y_ff;
   logic [1:0]            dirs_ff;
   logic                  moving_ff;
   logic [DB-1:0]         ax_ff, ay_ff;
   logic [LB-1:0]         len_ff;
   tsp_pkg::rsp_type      rsp_ff;
   logic                  alu_wait_ff;

   logic          alu_start, alu_div, alu_done;
   logic [AW-1:0] alu_a, alu_b, alu_res;

   tsp_alu #(.W(AW)) u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .is_div(alu_div),
      .opa(alu_a), .opb(alu_b), .done(alu_done), .result(alu_res)
   );

   logic signed [DB-1:0] dx, dy;
   logic [DB-1:0]        adx, ady;
   logic [SB-1:0]        sq_sum;
   logic [QB-1:0]        num;
   logic [AW-1:0]        per_raw;
   logic [PERIOD_BITS-1:0] per_sat;

   assign dx  = DB'($signed(req.target_x)) - DB'($signed(pos_x_ff));
   assign dy  = DB'($signed(req.target_y)) - DB'($signed(pos_y_ff));
   assign adx = dx[DB-1] ? DB'(-dx) : DB'(dx);
   assign ady = dy[DB-1] ? DB'(-dy) : DB'(dy);
   assign sq_sum = SB'(ax_ff * ax_ff) + SB'(ay_ff * ay_ff);
   assign num = QB'(base_ff * len_ff);

   always_comb begin
      per_raw = '0;
      per_sat = '0;
      if (alu_res >= AW'(tsp_pkg::PERIOD_OFFSET)) begin
         per_raw = alu_res - AW'(tsp_pkg::PERIOD_OFFSET);
         per_sat = (per_raw > AW'(PMAX)) ? PMAX : PERIOD_BITS'(per_raw);
      end
   end

   assign csr.ready = (state_ff == S_IDLE);
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.toggle_x = rsp_ff.toggle_x;
   assign rsp.toggle_y = rsp_ff.toggle_y;
   assign rsp.dir_x    = rsp_ff.dir_x;
   assign rsp.dir_y    = rsp_ff.dir_y;
   assign rsp.busy_res = rsp_ff.busy_res;
   assign rsp.rejected = rsp_ff.rejected;

   always_comb begin
      alu_start = 1'b0;
      alu_div   = 1'b0;
      alu_a     = AW'(sq_sum);
      alu_b     = '0;
      if (alu_wait_ff) begin
         alu_start = 1'b1;
         unique case (state_ff)
            S_SQRT: begin
               alu_div = 1'b0;
               alu_a   = AW'(sq_sum);
            end
            S_DIVX: begin
               alu_div = 1'b1;
               alu_a   = AW'(num);
               alu_b   = AW'(ax_ff);
            end
            S_DIVY: begin
               alu_div = 1'b1;
               alu_a   = AW'(num);
               alu_b   = AW'(ay_ff);
            end
            default: alu_start = 1'b0;
         endcase
      end
   end

   logic [PERIOD_BITS-1:0] cx, cy;
   logic                   hx, hy;
   logic [TB-1:0]          lx, ly;
   always_comb begin
      cx = (left_x_ff != '0 && count_x_ff != PMAX) ? count_x_ff + 1'b1 : count_x_ff;
      cy = (left_y_ff != '0 && count_y_ff != PMAX) ? count_y_ff + 1'b1 : count_y_ff;
      hx = (left_x_ff != '0) && ((cx > period_x_ff) || (cx == PMAX));
      hy = (left_y_ff != '0) && ((cy > period_y_ff) || (cy == PMAX));
      lx = hx ? left_x_ff - 1'b1 : left_x_ff;
      ly = hy ? left_y_ff - 1'b1 : left_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         base_ff     <= tsp_pkg::BASE_RESET;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         goal_x_ff   <= '0;
         goal_y_ff   <= '0;
         left_x_ff   <= '0;
         left_y_ff   <= '0;
         period_x_ff <= '0;
         period_y_ff <= '0;
         count_x_ff  <= '0;
         count_y_ff  <= '0;
         dirs_ff     <= '0;
         moving_ff   <= 1'b0;
         alu_wait_ff <= 1'b0;
      end else begin
         alu_wait_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr.valid) begin
                  base_ff <= csr.data;
               end
               if (req.valid) begin
                  if (req.req_type == tsp_pkg::REQ_MOVE) begin
                     if (moving_ff) begin
                        rsp_ff   <= '{1'b0, 1'b0, dirs_ff[0], dirs_ff[1], 1'b1, 1'b1};
                        state_ff <= S_RESP;
                     end else begin
                        goal_x_ff  <= req.target_x;
                        goal_y_ff  <= req.target_y;
                        ax_ff      <= adx;
                        ay_ff      <= ady;
                        dirs_ff    <= {!dy[DB-1] && dy != '0, !dx[DB-1] && dx != '0};
                        left_x_ff  <= TB'({adx, 1'b0});
                        left_y_ff  <= TB'({ady, 1'b0});
                        count_x_ff <= '0;
                        count_y_ff <= '0;
                        if (adx == '0 && ady == '0) begin
                           pos_x_ff    <= req.target_x;
                           pos_y_ff    <= req.target_y;
                           period_x_ff <= '0;
                           period_y_ff <= '0;
                           rsp_ff      <= '0;
                           state_ff    <= S_RESP;
                        end else begin
                           alu_wait_ff <= 1'b1;
                           state_ff    <= S_SQRT;
                        end
                     end
                  end else begin
                     if (moving_ff) begin
                        left_x_ff  <= lx;
                        left_y_ff  <= ly;
                        if (lx == '0 && ly == '0) begin
                           pos_x_ff   <= goal_x_ff;
                           pos_y_ff   <= goal_y_ff;
                           count_x_ff <= '0;
                           count_y_ff <= '0;
                           moving_ff  <= 1'b0;
                        end else begin
                           count_x_ff <= hx ? '0 : cx;
                           count_y_ff <= hy ? '0 : cy;
                        end
                     end
                     rsp_ff   <= '{moving_ff && hx, moving_ff && hy, dirs_ff[0], dirs_ff[1],
                                   moving_ff && (lx != '0 || ly != '0), 1'b0};
                     state_ff <= S_RESP;
                  end
               end
            end
            S_SQRT: begin
               if (alu_done) begin
                  len_ff      <= LB'(alu_res);
                  alu_wait_ff <= 1'b1;
                  state_ff    <= S_DIVX;
               end
            end
            S_DIVX: begin
               if (alu_done) begin
                  period_x_ff <= (ax_ff == '0) ? '0 : per_sat;
                  alu_wait_ff <= 1'b1;
                  state_ff    <= S_DIVY;
               end
            end
            S_DIVY: begin
               if (alu_done) begin
                  period_y_ff <= (ay_ff == '0) ? '0 : per_sat;
                  moving_ff   <= 1'b1;
                  rsp_ff      <= '{1'b0, 1'b0, dirs_ff[0], dirs_ff[1], 1'b1, 1'b0};
                  state_ff    <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- tb/tsp_checker.sv -----
// ----------------------------------------------------------------------------
// tsp_checker
// Watches the request, response and register channels of the step pulse
// planner, predicts every response beat and compares it field by field.
// ----------------------------------------------------------------------------
module tsp_checker (
   input  logic  clock,
   input  logic  reset,
   tsp_req_if    req,
   tsp_rsp_if    rsp,
   tsp_csr_if    csr,
   output int    errors,
   output int    pending,
   output logic  busy
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] PER_ALL_ONES = 32'hFFFF_FFFF;

   logic [tsp_pkg::BASE_BITS-1:0] base_q;
   logic [19:0]          pos_x, pos_y, goal_x, goal_y;
   logic [21:0]          left_x, left_y;
   logic [31:0]          per_x, per_y, cnt_x, cnt_y;
   logic [1:0]           dirs;
   logic                 moving;
   tsp_pkg::rsp_type     rsp_queue[$];

   assign busy    = moving;

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 23; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] tick_period(longint unsigned len, longint unsigned d,
                                               logic [tsp_pkg::BASE_BITS-1:0] base);
      longint unsigned q;
      if (d == 0) return '0;
      q = longint'(base) * len / d;
      if (q < tsp_pkg::PERIOD_OFFSET) return '0;
      q -= tsp_pkg::PERIOD_OFFSET;
      if (q > 64'hFFFF_FFFF) return PER_ALL_ONES;
      return q[31:0];
   endfunction

   task automatic check_bit(string name, logic exp_v, logic act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %0b actual %0b", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      tsp_pkg::rsp_type exp_r, act_r;
      longint          dx, dy;
      longint unsigned ax, ay, len;
      logic            tx, ty, rej;
      if (reset) begin
         base_q <= tsp_pkg::BASE_RESET;
         pos_x <= '0; pos_y <= '0; goal_x <= '0; goal_y <= '0;
         left_x <= '0; left_y <= '0; per_x <= '0; per_y <= '0;
         cnt_x <= '0; cnt_y <= '0; dirs <= '0; moving <= 1'b0;
         rsp_queue.delete();
         errors = 0;
         pending = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            act_r = '{rsp.toggle_x, rsp.toggle_y, rsp.dir_x, rsp.dir_y, rsp.busy_res,
                      rsp.rejected};
            if (rsp_queue.size() == 0) begin
               $display("%0t unexpected response beat: expected none actual %b",
                        $time, act_r);
               errors++;
            end else begin
               exp_r = rsp_queue.pop_front();
               check_bit("toggle_x", exp_r.toggle_x, act_r.toggle_x);
               check_bit("toggle_y", exp_r.toggle_y, act_r.toggle_y);
               check_bit("dir_x", exp_r.dir_x, act_r.dir_x);
               check_bit("dir_y", exp_r.dir_y, act_r.dir_y);
               check_bit("busy_res", exp_r.busy_res, act_r.busy_res);
               check_bit("rejected", exp_r.rejected, act_r.rejected);
            end
         end
         if (csr.valid && csr.ready) base_q <= csr.data;
         if (req.valid && req.ready) begin
            automatic logic [19:0] n_pos_x = pos_x, n_pos_y = pos_y;
            automatic logic [19:0] n_goal_x = goal_x, n_goal_y = goal_y;
            automatic logic [21:0] n_left_x = left_x, n_left_y = left_y;
            automatic logic [31:0] n_per_x = per_x, n_per_y = per_y;
            automatic logic [31:0] n_cnt_x = cnt_x, n_cnt_y = cnt_y;
            automatic logic [1:0]  n_dirs = dirs;
            automatic logic        n_moving = moving;
            tx = 1'b0; ty = 1'b0; rej = 1'b0;
            if (req.req_type == tsp_pkg::REQ_MOVE) begin
               if (moving) begin
                  rej = 1'b1;
               end else begin
                  dx = longint'($signed(req.target_x)) - longint'($signed(pos_x));
                  dy = longint'($signed(req.target_y)) - longint'($signed(pos_y));
                  ax = (dx < 0) ? -dx : dx;
                  ay = (dy < 0) ? -dy : dy;
                  len = floor_sqrt(ax * ax + ay * ay);
                  n_goal_x = req.target_x;
                  n_goal_y = req.target_y;
                  n_dirs = {dy > 0, dx > 0};
                  n_per_x = tick_period(len, ax, base_q);
                  n_per_y = tick_period(len, ay, base_q);
                  n_left_x = 22'(2 * ax);
                  n_left_y = 22'(2 * ay);
                  n_cnt_x = '0; n_cnt_y = '0;
                  n_moving = (n_left_x != 0) || (n_left_y != 0);
                  if (!n_moving) begin
                     n_pos_x = n_goal_x;
                     n_pos_y = n_goal_y;
                  end
               end
            end else if (moving) begin
               if (n_left_x != 0) begin
                  if (n_cnt_x != PER_ALL_ONES) n_cnt_x++;
                  if (n_cnt_x > n_per_x || n_cnt_x == PER_ALL_ONES) begin
                     n_cnt_x = '0; n_left_x--; tx = 1'b1;
                  end
               end
               if (n_left_y != 0) begin
                  if (n_cnt_y != PER_ALL_ONES) n_cnt_y++;
                  if (n_cnt_y > n_per_y || n_cnt_y == PER_ALL_ONES) begin
                     n_cnt_y = '0; n_left_y--; ty = 1'b1;
                  end
               end
               if (n_left_x == 0 && n_left_y == 0) begin
                  n_pos_x = goal_x; n_pos_y = goal_y;
                  n_cnt_x = '0; n_cnt_y = '0; n_moving = 1'b0;
               end
            end
            rsp_queue.push_back(tsp_pkg::rsp_type'{tx, ty, n_dirs[0], n_dirs[1], n_moving,
                                                   rej});
            pos_x <= n_pos_x; pos_y <= n_pos_y; goal_x <= n_goal_x; goal_y <= n_goal_y;
            left_x <= n_left_x; left_y <= n_left_y; per_x <= n_per_x; per_y <= n_per_y;
            cnt_x <= n_cnt_x; cnt_y <= n_cnt_y; dirs <= n_dirs; moving <= n_moving;
         end
         pending = rsp_queue.size();
      end
   end

endmodule

// ----- tb/tb_two_axis_step_pulse_planner_unit.sv -----
// ----------------------------------------------------------------------------
// tb_two_axis_step_pulse_planner_unit
// Drives long directed and short random moves with tick trains, rejected moves and
// idle ticks through the planner under several base periods and idle/stall mixes;
// the checker compares every response beat against its own prediction.
// ----------------------------------------------------------------------------
module tb_two_axis_step_pulse_planner_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors, pending;
   logic busy;
   int   send_pct = 0, stall_pct = 0;
   int   hold_req = 0, hold_left = 0;
   int   cycles = 0;
   int   item_count;
   logic [19:0] cur_x = '0, cur_y = '0;

   tsp_req_if #(.POS_BITS(20)) req_ch();
   tsp_rsp_if                  rsp_ch();
   tsp_csr_if                  csr_ch();

   two_axis_step_pulse_planner_unit uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );

   tsp_checker chk (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .errors(errors), .pending(pending), .busy(busy)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random stall, plus long hold-off on request
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_beat(logic kind, logic [19:0] tx, logic [19:0] ty);
      while ($urandom_range(99) < send_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.req_type = kind;
      req_ch.target_x = tx;
      req_ch.target_y = ty;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
      item_count++;
   endtask

   task automatic write_base(logic [15:0] value);
      while (pending != 0) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // move by a small offset, then tick until done; some rejected moves mixed in
   task automatic move_and_drain(int max_d);
      logic [19:0] nx, ny;
      nx = cur_x + 20'($signed($urandom_range(2 * max_d)) - max_d);
      ny = cur_y + 20'($signed($urandom_range(2 * max_d)) - max_d);
      send_beat(tsp_pkg::REQ_MOVE, nx, ny);
      cur_x = nx;
      cur_y = ny;
      while (busy) begin
         if ($urandom_range(99) < 8)
            send_beat(tsp_pkg::REQ_MOVE, 20'($urandom), 20'($urandom));
         else
            send_beat(tsp_pkg::REQ_TICK, 20'($urandom), 20'($urandom));
      end
      if ($urandom_range(99) < 15)
         send_beat(tsp_pkg::REQ_TICK, 20'($urandom), 20'($urandom));
   endtask

   task automatic run_phase(int s_pct, int r_pct, int n_items, int max_d);
      int start;
      send_pct  = s_pct;
      stall_pct = r_pct;
      start = item_count;
      while (item_count - start < n_items) begin
         case ($urandom_range(5))
            0: write_base(16'($urandom_range(3)));
            1: write_base(16'($urandom_range(12, 4)));
            default: ;
         endcase
         move_and_drain(max_d);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0; req_ch.req_type = tsp_pkg::REQ_TICK;
      req_ch.target_x = '0; req_ch.target_y = '0;
      csr_ch.valid = 1'b0; csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      item_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_beat(tsp_pkg::REQ_TICK, '0, '0);
      send_beat(tsp_pkg::REQ_MOVE, '0, '0);
      send_beat(tsp_pkg::REQ_MOVE, 20'd1, '0);
      send_beat(tsp_pkg::REQ_MOVE, 20'h7FFFF, 20'h80000);
      while (busy) send_beat(tsp_pkg::REQ_TICK, '0, '0);
      write_base(16'd4);
      send_beat(tsp_pkg::REQ_MOVE, 20'd1, 20'hFFFFF);
      send_beat(tsp_pkg::REQ_MOVE, 20'h80000, 20'h7FFFF);
      while (busy) send_beat(tsp_pkg::REQ_TICK, 20'hFFFFF, 20'hFFFFF);
      send_beat(tsp_pkg::REQ_MOVE, 20'hFFFFE, 20'd1);
      while (busy) send_beat(tsp_pkg::REQ_TICK, '0, '0);
      cur_x = 20'hFFFFE; cur_y = 20'd1;
      write_base(16'd0);
      send_beat(tsp_pkg::REQ_MOVE, 20'hFFFFF, 20'd3);
      while (busy) send_beat(tsp_pkg::REQ_TICK, '0, '0);
      cur_x = 20'hFFFFF; cur_y = 20'd3;

      // random phases; long response hold-off in the first
      hold_req = 400;
      run_phase(0, 0, 180, 3);
      run_phase(85, 0, 180, 3);
      run_phase(0, 85, 180, 3);
      run_phase(28, 28, 180, 3);
      write_base(16'd125);
      run_phase(0, 0, 40, 1);

      // extreme move with saturated Y period, left unfinished
      write_base(16'hFFFF);
      send_beat(tsp_pkg::REQ_MOVE, cur_x + 20'h7FFFF, cur_y + 20'd1);
      repeat (20) send_beat(tsp_pkg::REQ_TICK, '0, '0);

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
